// ----- src/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT       = 2'd0,
        REQ_EXTRACT_HEAD = 2'd1,
        REQ_EXTRACT_EXACT = 2'd2,
        REQ_EXTRACT_LE   = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    localparam int PRIO_PORT_BITS = 8;
    localparam int PAYLOAD_BITS   = 32;
    localparam int FILL_BITS      = 5;

    // request decoded once at the top and broadcast down the chain
    typedef struct packed {
        logic ins_go;
        logic head_go;
        logic exact_go;
    } spq_cmd_t;

    // compare flags one cell hands to its right neighbor
    typedef struct packed {
        logic le;
        logic eq;
    } spq_flags_t;

endpackage

`default_nettype wire

// ----- src/spq_cell.sv -----
`default_nettype none

module spq_cell #(
    parameter int PRIO_BITS = 8
) (
    input  wire logic                               clk,
    input  wire spq_pkg::spq_cmd_t                  cmd,
    input  wire logic [PRIO_BITS-1:0]               key,
    input  wire logic [spq_pkg::PAYLOAD_BITS-1:0]   new_payload,
    input  wire logic                               occupied,
    input  wire spq_pkg::spq_flags_t                left_flags,
    input  wire logic [PRIO_BITS-1:0]               left_prio,
    input  wire logic [spq_pkg::PAYLOAD_BITS-1:0]   left_payload,
    input  wire logic [PRIO_BITS-1:0]               right_prio,
    input  wire logic [spq_pkg::PAYLOAD_BITS-1:0]   right_payload,
    output spq_pkg::spq_flags_t                     flags,
    output logic                                    first_hit,
    output logic [PRIO_BITS-1:0]                    prio,
    output logic [spq_pkg::PAYLOAD_BITS-1:0]        payload
);
    import spq_pkg::*;

    logic [PRIO_BITS-1:0]    prio_reg;
    logic [PRIO_BITS-1:0]    prio_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;
    logic                    ge_key;

    always_comb
    begin
        flags.le  = occupied && (prio_reg <= key);
        flags.eq  = occupied && (prio_reg == key);
        ge_key    = prio_reg >= key;
        first_hit = flags.eq && !left_flags.eq;

        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (cmd.ins_go && !flags.le)
        begin
            // open a slot: the boundary cell loads the new beat, cells past it shift right
            if (left_flags.le)
            begin
                prio_next    = key;
                payload_next = new_payload;
            end
            else
            begin
                prio_next    = left_prio;
                payload_next = left_payload;
            end
        end
        else if (cmd.head_go || (cmd.exact_go && ge_key))
        begin
            // close the gap from the right
            prio_next    = right_prio;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue_unit.sv -----
// Sorted priority queue, lowest priority number first, ties kept in arrival order.
// Each beat on s_* is one request (tuser: 0 insert, 1 extract head, 2 extract
// exact priority, 3 extract head if its priority is at most the key) and gives
// exactly one result beat on m_* in the next cycle. A new request is taken every
// cycle while the result register is empty or being drained. The entries sit in
// a chain of CAPACITY cells that all update in the same cycle from their own
// compare and their left neighbor's; an exact extract additionally ORs the hit
// flags of all cells and selects the hit cell's payload. The queue is empty
// after reset and needs no initialization time.
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int CAPACITY  = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // prio_key[7:0], payload[39:8]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_prio[7:0], out_payload[39:8], fill_level[44:40]
    output logic [1:0]       m_tuser    // status[1:0]
);
    import spq_pkg::*;

    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    logic [OCC_BITS-1:0]       occ_reg;
    logic [OCC_BITS-1:0]       occ_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [PRIO_PORT_BITS-1:0] out_prio_reg;
    logic [PRIO_PORT_BITS-1:0] out_prio_next;
    logic [PAYLOAD_BITS-1:0]   out_payload_reg;
    logic [PAYLOAD_BITS-1:0]   out_payload_next;
    logic [FILL_BITS-1:0]      fill_reg;
    logic [FILL_BITS-1:0]      fill_next;

    logic                    accept;
    req_kind_t               kind;
    logic [PRIO_BITS-1:0]    key;
    logic [PAYLOAD_BITS-1:0] in_payload;
    logic                    full;
    logic                    empty;
    logic                    hit_any;
    logic [PAYLOAD_BITS-1:0] hit_payload;
    logic                    head_ok;
    logic                    exact_ok;
    logic                    ins_ok;
    spq_cmd_t                cmd;

    logic [PRIO_BITS-1:0]    cell_prio    [CAPACITY];
    logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
    spq_flags_t              cell_flags   [CAPACITY];
    logic                    cell_first   [CAPACITY];

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign kind       = req_kind_t'(s_tuser);
    assign key        = PRIO_BITS'(s_tdata[7:0]);
    assign in_payload = s_tdata[39:8];
    assign full       = occ_reg == OCC_BITS'(CAPACITY);
    assign empty      = occ_reg == '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            spq_flags_t              lf;
            logic [PRIO_BITS-1:0]    lp;
            logic [PAYLOAD_BITS-1:0] lv;
            logic [PRIO_BITS-1:0]    rp;
            logic [PAYLOAD_BITS-1:0] rv;

            if (gi == 0)
            begin : g_head
                assign lf = '{le: 1'b1, eq: 1'b0};
                assign lp = key;
                assign lv = in_payload;
            end
            else
            begin : g_mid
                assign lf = cell_flags[gi-1];
                assign lp = cell_prio[gi-1];
                assign lv = cell_payload[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rp = cell_prio[gi];
                assign rv = cell_payload[gi];
            end
            else
            begin : g_inner
                assign rp = cell_prio[gi+1];
                assign rv = cell_payload[gi+1];
            end

            spq_cell #(
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .clk           (clk),
                .cmd           (cmd),
                .key           (key),
                .new_payload   (in_payload),
                .occupied      (occ_reg > OCC_BITS'(gi)),
                .left_flags    (lf),
                .left_prio     (lp),
                .left_payload  (lv),
                .right_prio    (rp),
                .right_payload (rv),
                .flags         (cell_flags[gi]),
                .first_hit     (cell_first[gi]),
                .prio          (cell_prio[gi]),
                .payload       (cell_payload[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit_any     = 1'b0;
        hit_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_any     = hit_any | cell_flags[i].eq;
            hit_payload = hit_payload | (cell_first[i] ? cell_payload[i] : '0);
        end
    end

    always_comb
    begin
        head_ok  = !empty && ((kind == REQ_EXTRACT_HEAD) ||
                              ((kind == REQ_EXTRACT_LE) && (cell_prio[0] <= key)));
        exact_ok = (kind == REQ_EXTRACT_EXACT) && hit_any;
        ins_ok   = (kind == REQ_INSERT) && !full;

        cmd.ins_go   = accept && ins_ok;
        cmd.head_go  = accept && head_ok;
        cmd.exact_go = accept && exact_ok;

        occ_next = occ_reg;
        if (cmd.ins_go)
        begin
            occ_next = occ_reg + OCC_BITS'(1);
        end
        else if (cmd.head_go || cmd.exact_go)
        begin
            occ_next = occ_reg - OCC_BITS'(1);
        end

        status_next      = status_reg;
        out_prio_next    = out_prio_reg;
        out_payload_next = out_payload_reg;
        fill_next        = fill_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        if (accept)
        begin
            out_valid_next   = 1'b1;
            out_prio_next    = '0;
            out_payload_next = '0;
            fill_next        = FILL_BITS'(occ_next);
            if (ins_ok)
            begin
                status_next = ST_OK;
            end
            else if (kind == REQ_INSERT)
            begin
                status_next = ST_FULL;
            end
            else if (head_ok)
            begin
                status_next      = ST_OK;
                out_prio_next    = PRIO_PORT_BITS'(cell_prio[0]);
                out_payload_next = cell_payload[0];
            end
            else if (exact_ok)
            begin
                status_next      = ST_OK;
                out_prio_next    = PRIO_PORT_BITS'(key);
                out_payload_next = hit_payload;
            end
            else
            begin
                status_next = ST_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, held while the beat waits
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        out_prio_reg    <= out_prio_next;
        out_payload_reg <= out_payload_next;
        fill_reg        <= fill_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, fill_reg, out_payload_reg, out_prio_reg};

endmodule

`default_nettype wire

// ----- src/spq_checker.sv -----
`default_nettype none

module spq_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    import spq_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // every accepted request yields a result beat next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    // failed requests carry no entry
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> m_tdata[39:0] == 40'd0)
        else $error("failed request returned entry data");

    // a full report means the store holds CAPACITY entries
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[44:40] == FILL_BITS'(CAPACITY))
        else $error("full status with wrong fill level");

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
